// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KNM_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("knm assertion failed");
`define KNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("knm assertion failed");
`else
`define KNM_ASSERT(label, cond)
`define KNM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/knm_pkg.sv -----
// Shared types, constants and the short-distance table for the knight distance block.
package knm_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int CW          = COORD_WIDTH;
  localparam int RES_W       = CW + 1;
  localparam int COUNT_W     = 32;
  localparam int TBL_N       = 10;
  localparam int IDX_W       = $clog2(TBL_N);
  localparam int DIST_W      = 3;

  typedef logic [CW-1:0]    coord_t;
  typedef logic [RES_W-1:0] res_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
  } delta_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    res_t   res;
  } resid_t;

  // ceil(2^(CW+1) / 3): n / 3 == (n * DIV3_MAGIC) >> (CW + 1) for any CW-bit n
  localparam logic [CW+1:0] DIV3_POW2   = (CW+2)'(1) << (CW + 1);
  localparam logic [CW+1:0] DIV3_WIDE   = (DIV3_POW2 + (CW+2)'(2)) / (CW+2)'(3);
  localparam logic [CW:0]   DIV3_MAGIC  = DIV3_WIDE[CW:0];

  localparam dist_t SMALL_DIST [TBL_N][TBL_N] = '{
    '{3'd0, 3'd3, 3'd2, 3'd3, 3'd2, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5},
    '{3'd3, 3'd2, 3'd1, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd5, 3'd6},
    '{3'd2, 3'd1, 3'd4, 3'd3, 3'd2, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5},
    '{3'd3, 3'd2, 3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd5, 3'd6},
    '{3'd2, 3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5},
    '{3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd6},
    '{3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd6, 3'd5},
    '{3'd5, 3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd5, 3'd6, 3'd5, 3'd6},
    '{3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd5, 3'd6, 3'd5, 3'd6, 3'd7},
    '{3'd5, 3'd6, 3'd5, 3'd6, 3'd5, 3'd6, 3'd5, 3'd6, 3'd7, 3'd6}
  };

endpackage

// ----- hw/rtl/knm_diff.sv -----
// Input register and absolute coordinate differences.
module knm_diff (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [knm_pkg::CW-1:0]        from_x,
  input  logic signed [knm_pkg::CW-1:0]        from_y,
  input  logic signed [knm_pkg::CW-1:0]        to_x,
  input  logic signed [knm_pkg::CW-1:0]        to_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output knm_pkg::delta_t                      out_delta
);

  localparam int CW = knm_pkg::CW;

  function automatic knm_pkg::coord_t abs_diff(logic signed [CW-1:0] a,
                                               logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    d = {a[CW-1], a} - {b[CW-1], b};
    return d[CW] ? CW'(-d) : CW'(d);
  endfunction

  logic                 v0;
  logic                 rdy0;
  logic signed [CW-1:0] fx, fy, tx, ty;
  logic                 v1;
  logic                 rdy1;
  knm_pkg::delta_t      delta;
  knm_pkg::delta_t      delta_next;

  assign rdy1     = !v1 || out_ready;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= in_valid;
    end
    if (rdy0 && in_valid) begin
      fx <= from_x;
      fy <= from_y;
      tx <= to_x;
      ty <= to_y;
    end
  end

  always_comb begin
    delta_next.cx = abs_diff(fx, tx);
    delta_next.cy = abs_diff(fy, ty);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= v0;
    end
    if (rdy1 && v0) begin
      delta <= delta_next;
    end
  end

  assign out_valid = v1;
  assign out_delta = delta;

endmodule

// ----- hw/rtl/knm_axis_reduce.sv -----
// Removes runs of (2,1) / (1,2) moves along the longer axis.
module knm_axis_reduce (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  knm_pkg::delta_t  in_delta,
  output logic             out_valid,
  input  logic             out_ready,
  output knm_pkg::resid_t  out_resid
);

  localparam int CW = knm_pkg::CW;

  // stage 1: order the axes, precompute bounds
  logic            v1, rdy1;
  logic            swap, swap_next;
  knm_pkg::coord_t lng, sht, diff, lim_a, lim_b;
  knm_pkg::coord_t lng_next, sht_next, lim_a_next, lim_b_next;

  // stage 2: run length
  logic            v2, rdy2;
  logic            swap2;
  knm_pkg::coord_t lng2, sht2, run, run_next;
  knm_pkg::coord_t min_a, max_b;

  // stage 3: apply the run
  logic            v3, rdy3;
  knm_pkg::resid_t resid, resid_next;
  knm_pkg::coord_t lng_sub, sht_sub;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    swap_next  = !(in_delta.cx > in_delta.cy);
    lng_next   = swap_next ? in_delta.cy : in_delta.cx;
    sht_next   = swap_next ? in_delta.cx : in_delta.cy;
    lim_a_next = (lng_next > CW'(knm_pkg::TBL_N - 2)) ?
                 ((lng_next - CW'(knm_pkg::TBL_N - 2)) >> 1) : '0;
    lim_b_next = (sht_next > CW'(knm_pkg::TBL_N - 1)) ?
                 (sht_next - CW'(knm_pkg::TBL_N - 1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      swap  <= swap_next;
      lng   <= lng_next;
      sht   <= sht_next;
      diff  <= lng_next - sht_next;
      lim_a <= lim_a_next;
      lim_b <= lim_b_next;
    end
  end

  always_comb begin
    min_a    = (sht < diff) ? sht : diff;
    max_b    = (lim_a > lim_b) ? lim_a : lim_b;
    run_next = (min_a < max_b) ? min_a : max_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      swap2 <= swap;
      lng2  <= lng;
      sht2  <= sht;
      run   <= run_next;
    end
  end

  always_comb begin
    lng_sub        = lng2 - {run[CW-2:0], 1'b0};
    sht_sub        = sht2 - run;
    resid_next.cx  = swap2 ? sht_sub : lng_sub;
    resid_next.cy  = swap2 ? lng_sub : sht_sub;
    resid_next.res = knm_pkg::res_t'(run);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      resid <= resid_next;
    end
  end

  assign out_valid = v3;
  assign out_resid = resid;

endmodule

// ----- hw/rtl/knm_diag_reduce.sv -----
// Removes runs of (3,3) double moves; divide by 3 through a reciprocal multiply.
module knm_diag_reduce (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  knm_pkg::resid_t  in_resid,
  output logic             out_valid,
  input  logic             out_ready,
  output knm_pkg::resid_t  out_resid
);

  localparam int CW   = knm_pkg::CW;
  localparam int PW   = 2 * CW + 1;

  // stage 1: both large, max - 7, min
  logic            v1, rdy1;
  knm_pkg::resid_t r1;
  logic            both, both_next;
  knm_pkg::coord_t hi_off, lo, hi_next, lo_next;

  // stage 2: products
  logic            v2, rdy2;
  knm_pkg::resid_t r2;
  logic            both2;
  logic [PW-1:0]   prod_hi, prod_lo;

  // stage 3: run length
  logic            v3, rdy3;
  knm_pkg::resid_t r3;
  knm_pkg::coord_t run, run_next, q_hi, q_lo;

  // stage 4: apply
  logic            v4, rdy4;
  knm_pkg::resid_t resid, resid_next;
  logic [CW+1:0]   run3;

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    both_next = (in_resid.cx >= CW'(knm_pkg::TBL_N)) &&
                (in_resid.cy >= CW'(knm_pkg::TBL_N));
    hi_next   = (in_resid.cx > in_resid.cy) ? in_resid.cx : in_resid.cy;
    lo_next   = (in_resid.cx > in_resid.cy) ? in_resid.cy : in_resid.cx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      r1     <= in_resid;
      both   <= both_next;
      hi_off <= hi_next - CW'(knm_pkg::TBL_N - 3);
      lo     <= lo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      r2      <= r1;
      both2   <= both;
      prod_hi <= PW'(hi_off) * PW'(knm_pkg::DIV3_MAGIC);
      prod_lo <= PW'(lo) * PW'(knm_pkg::DIV3_MAGIC);
    end
  end

  always_comb begin
    q_hi     = prod_hi[PW-1:CW+1];
    q_lo     = prod_lo[PW-1:CW+1];
    run_next = !both2 ? '0 : ((q_hi < q_lo) ? q_hi : q_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      r3  <= r2;
      run <= run_next;
    end
  end

  always_comb begin
    run3           = (CW+2)'(run) + {1'b0, run, 1'b0};
    resid_next.cx  = r3.cx - CW'(run3);
    resid_next.cy  = r3.cy - CW'(run3);
    resid_next.res = r3.res + {run, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4 && v3) begin
      resid <= resid_next;
    end
  end

  assign out_valid = v4;
  assign out_resid = resid;

endmodule

// ----- hw/rtl/knm_finish.sv -----
// Straight (4,0) runs, table lookup, saturation and the output register.
module knm_finish (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  knm_pkg::resid_t               in_resid,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [knm_pkg::COUNT_W-1:0]   out_count
);

  localparam int CW     = knm_pkg::CW;
  localparam int COUNT_W = knm_pkg::COUNT_W;
  localparam int SAT_W  = (knm_pkg::RES_W > COUNT_W) ? knm_pkg::RES_W : COUNT_W;

  // stage 1: straight runs and table indexes
  logic            v1, rdy1;
  knm_pkg::coord_t rx, ry, cx_adj, cy_adj;
  knm_pkg::res_t   res, res_next;
  knm_pkg::idx_t   ix, iy, ix_next, iy_next;

  // stage 2: output register
  logic               v2, rdy2;
  knm_pkg::res_t      total;
  logic [SAT_W-1:0]   total_wide;
  logic [COUNT_W-1:0] count, count_next;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    rx       = in_resid.cx - CW'(knm_pkg::TBL_N);
    ry       = in_resid.cy - CW'(knm_pkg::TBL_N);
    cx_adj   = in_resid.cx;
    cy_adj   = in_resid.cy;
    res_next = in_resid.res;
    if (in_resid.cx >= CW'(knm_pkg::TBL_N)) begin
      cx_adj   = CW'(knm_pkg::TBL_N - 4) + CW'(rx[1:0]);
      res_next = in_resid.res +
                 ((knm_pkg::res_t'(rx >> 2) + knm_pkg::res_t'(1)) << 1);
    end else if (in_resid.cy >= CW'(knm_pkg::TBL_N)) begin
      cy_adj   = CW'(knm_pkg::TBL_N - 4) + CW'(ry[1:0]);
      res_next = in_resid.res +
                 ((knm_pkg::res_t'(ry >> 2) + knm_pkg::res_t'(1)) << 1);
    end
    ix_next = (cx_adj >= CW'(knm_pkg::TBL_N)) ?
              knm_pkg::IDX_W'(knm_pkg::TBL_N - 1) : cx_adj[knm_pkg::IDX_W-1:0];
    iy_next = (cy_adj >= CW'(knm_pkg::TBL_N)) ?
              knm_pkg::IDX_W'(knm_pkg::TBL_N - 1) : cy_adj[knm_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      res <= res_next;
      ix  <= ix_next;
      iy  <= iy_next;
    end
  end

  always_comb begin
    total      = res + knm_pkg::res_t'(knm_pkg::SMALL_DIST[iy][ix]);
    total_wide = SAT_W'(total);
    count_next = (total_wide > SAT_W'({COUNT_W{1'b1}})) ? '1 : COUNT_W'(total_wide);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      count <= count_next;
    end
  end

  assign out_valid = v2;
  assign out_count = count;

endmodule

// ----- hw/rtl/knight_move_distance.sv -----
// Top level: fewest knight moves between two points on an unbounded board.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid in_ready from_x from_y to_x to_y | into block
//   out     | out_valid out_ready move_count       | out of block
//
// One transfer per cycle sustained while out_ready stays high; a result passes
// through eleven pipeline registers on its way to out_valid (the input register
// loads on the transfer edge; the divide-by-3 multiply has a stage of its own).
// Every stage holds while its successor is full and stalled,
// so empty stages keep taking input while a result waits. rst clears all valids.
`include "assert_macros.svh"

module knight_move_distance (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [knm_pkg::CW-1:0]        from_x,
  input  logic signed [knm_pkg::CW-1:0]        from_y,
  input  logic signed [knm_pkg::CW-1:0]        to_x,
  input  logic signed [knm_pkg::CW-1:0]        to_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [knm_pkg::COUNT_W-1:0]          move_count
);

  localparam knm_pkg::coord_t TBL_LIM = knm_pkg::CW'(knm_pkg::TBL_N);

  logic            diff_valid, diff_ready;
  knm_pkg::delta_t diff_delta;
  logic            axis_valid, axis_ready;
  knm_pkg::resid_t axis_resid;
  logic            diag_valid, diag_ready;
  knm_pkg::resid_t diag_resid;

  knm_diff u_diff (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .from_x    (from_x),
    .from_y    (from_y),
    .to_x      (to_x),
    .to_y      (to_y),
    .out_valid (diff_valid),
    .out_ready (diff_ready),
    .out_delta (diff_delta)
  );

  knm_axis_reduce u_axis (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (diff_valid),
    .in_ready  (diff_ready),
    .in_delta  (diff_delta),
    .out_valid (axis_valid),
    .out_ready (axis_ready),
    .out_resid (axis_resid)
  );

  knm_diag_reduce u_diag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (axis_valid),
    .in_ready  (axis_ready),
    .in_resid  (axis_resid),
    .out_valid (diag_valid),
    .out_ready (diag_ready),
    .out_resid (diag_resid)
  );

  knm_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (diag_valid),
    .in_ready  (diag_ready),
    .in_resid  (diag_resid),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_count (move_count)
  );

  // after the diagonal runs, at most one residual is still off the table
  `KNM_ASSERT(a_diag_resid, !diag_valid || (diag_resid.cx < TBL_LIM) || (diag_resid.cy < TBL_LIM))
  `KNM_ASSERT(a_ready_chain, !out_ready || in_ready)
  `KNM_ASSERT(a_axis_stall, !$past(axis_valid && !axis_ready) || (axis_valid && $stable(axis_resid)))
  `KNM_ASSERT_NEXT(a_reset_empty, rst, !out_valid)

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for knight_move_distance: directed rows, random pairs, flow control.
`timescale 1ns / 100ps

module tb_top;

  localparam int      CW         = knm_pkg::CW;
  localparam int      COUNT_W    = knm_pkg::COUNT_W;

  typedef knm_pkg::coord_t coord_t;

  localparam int      N_RANDOM   = 1200;
  localparam int      CYCLE_CAP  = 200000;
  localparam int      DRAIN_CAP  = 5000;
  localparam int      TAIL_WAIT  = 30;
  localparam int      LONG_HOLD  = 400;
  localparam int      HOP_N      = 10;
  localparam coord_t  CMIN       = coord_t'(1) << (CW - 1);
  localparam coord_t  CMAX       = ~CMIN;
  localparam coord_t  CNEG1      = '1;

  localparam int unsigned SHORT_HOPS [HOP_N][HOP_N] = '{
    '{0, 3, 2, 3, 2, 3, 4, 5, 4, 5},
    '{3, 2, 1, 2, 3, 4, 3, 4, 5, 6},
    '{2, 1, 4, 3, 2, 3, 4, 5, 4, 5},
    '{3, 2, 3, 2, 3, 4, 3, 4, 5, 6},
    '{2, 3, 2, 3, 4, 3, 4, 5, 4, 5},
    '{3, 4, 3, 4, 3, 4, 5, 4, 5, 6},
    '{4, 3, 4, 3, 4, 5, 4, 5, 6, 5},
    '{5, 4, 5, 4, 5, 4, 5, 6, 5, 6},
    '{4, 5, 4, 5, 4, 5, 6, 5, 6, 7},
    '{5, 6, 5, 6, 5, 6, 5, 6, 7, 6}
  };

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct {
    coord_t fx;
    coord_t fy;
    coord_t tx;
    coord_t ty;
    bit     fixed;
    count_t moves;
  } pair_row_t;

  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic signed [CW-1:0]    from_x     = '0;
  logic signed [CW-1:0]    from_y     = '0;
  logic signed [CW-1:0]    to_x       = '0;
  logic signed [CW-1:0]    to_y       = '0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic [COUNT_W-1:0]      move_count;

  bit                      row_fixed     = 1'b0;
  count_t                  row_moves     = '0;
  count_t                  pending_moves [$];
  int                      errors        = 0;
  bit                      long_hold_req = 1'b0;

  knight_move_distance u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .from_x     (from_x),
    .from_y     (from_y),
    .to_x       (to_x),
    .to_y       (to_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .move_count (move_count)
  );

  always #4 clk = ~clk;

  function automatic bit [63:0] min64(input bit [63:0] a, input bit [63:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic bit [63:0] max64(input bit [63:0] a, input bit [63:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic bit [63:0] floor_sub(input bit [63:0] a, input bit [63:0] b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  // two's complement -> offset binary keeps order, then unsigned distance
  function automatic bit [63:0] axis_gap(input coord_t a, input coord_t b);
    bit [63:0] ua;
    bit [63:0] ub;
    ua = 64'(a ^ CMIN);
    ub = 64'(b ^ CMIN);
    return (ua > ub) ? ua - ub : ub - ua;
  endfunction

  function automatic count_t knight_moves(input coord_t fx, input coord_t fy,
                                          input coord_t tx, input coord_t ty);
    bit [63:0] cx;
    bit [63:0] cy;
    bit [63:0] hops;
    bit [63:0] run;
    cx   = axis_gap(fx, tx);
    cy   = axis_gap(fy, ty);
    hops = 0;
    if (cx > cy) begin
      run = min64(min64(cy, cx - cy),
                  max64(floor_sub(cx, HOP_N - 2) / 2, floor_sub(cy, HOP_N - 1)));
      cx  = cx - 2 * run;
      cy  = cy - run;
    end else begin
      run = min64(min64(cx, cy - cx),
                  max64(floor_sub(cx, HOP_N - 1), floor_sub(cy, HOP_N - 2) / 2));
      cx  = cx - run;
      cy  = cy - 2 * run;
    end
    hops = hops + run;
    if (cx >= HOP_N && cy >= HOP_N) begin
      run  = min64(max64((cx - (HOP_N - 3)) / 3, (cy - (HOP_N - 3)) / 3),
                   min64(cx / 3, cy / 3));
      cx   = cx - 3 * run;
      cy   = cy - 3 * run;
      hops = hops + 2 * run;
    end
    if (cx >= HOP_N) begin
      run  = (cx - HOP_N) / 4 + 1;
      cx   = cx - 4 * run;
      hops = hops + 2 * run;
    end else if (cy >= HOP_N) begin
      run  = (cy - HOP_N) / 4 + 1;
      cy   = cy - 4 * run;
      hops = hops + 2 * run;
    end
    if (cx >= HOP_N) cx = HOP_N - 1;
    if (cy >= HOP_N) cy = HOP_N - 1;
    hops = hops + SHORT_HOPS[cy][cx];
    if (hops > 64'hFFFF_FFFF) hops = 64'hFFFF_FFFF;
    return count_t'(hops);
  endfunction

  task automatic report(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // drives one pair and returns at the edge where it transfers
  task automatic send_pair(input coord_t fx, input coord_t fy, input coord_t tx,
                           input coord_t ty, input bit fixed, input count_t moves);
    from_x    <= fx;
    from_y    <= fy;
    to_x      <= tx;
    to_y      <= ty;
    row_fixed <= fixed;
    row_moves <= moves;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_moves.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0:       return CMIN;
      1:       return CMAX;
      2:       return '0;
      3:       return CNEG1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic next_pair(output coord_t fx, output coord_t fy,
                           output coord_t tx, output coord_t ty);
    int mode;
    mode = $urandom_range(0, 9);
    fx   = coord_t'($urandom);
    fy   = coord_t'($urandom);
    tx   = coord_t'($urandom);
    ty   = coord_t'($urandom);
    case (mode)
      3, 4, 5: begin
        tx = fx + coord_t'($urandom_range(0, 80) - 40);
        ty = fy + coord_t'($urandom_range(0, 80) - 40);
      end
      6, 7: begin
        tx = fx + coord_t'($urandom_range(0, 10000) - 5000);
        ty = fy + coord_t'($urandom_range(0, 10000) - 5000);
        if ($urandom_range(0, 3) == 0) ty = coord_t'($urandom);
      end
      8: begin
        fx = pick_extreme();
        fy = pick_extreme();
        tx = pick_extreme();
        ty = pick_extreme();
      end
      9: begin
        if ($urandom_range(0, 1) != 0) tx = fx;
        else ty = fy;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    count_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_moves.size() == 0) begin
          report($sformatf("unexpected transfer, move_count=%0d", move_count));
        end else begin
          want = pending_moves.pop_front();
          if (move_count !== want)
            report($sformatf("move_count=%0d, predicted %0d", move_count, want));
        end
      end
      if (in_valid && in_ready)
        pending_moves.insert(pending_moves.size(),
                             row_fixed ? row_moves
                                       : knight_moves(from_x, from_y, to_x, to_y));
    end
  end

  initial begin : receiver
    int  run;
    bit  rdy;
    run = 0;
    rdy = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rdy = 1'b0;
        run = LONG_HOLD;
      end else if (run == 0) begin
        rdy = !rdy;
        run = rdy ? $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8)
                  : $urandom_range(1, 5);
      end
      run--;
      out_ready <= rdy;
    end
  end

  initial begin : watchdog
    repeat (CYCLE_CAP) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    pair_row_t rows [] = '{
      '{'0,   '0,   '0,   '0,   1'b1, 0},
      '{CMIN, CMIN, CMIN, CMIN, 1'b1, 0},
      '{CMAX, CMAX, CMAX, CMAX, 1'b1, 0},
      '{'0,   '0,   2,    1,    1'b1, 1},
      '{'0,   '0,   1,    2,    1'b1, 1},
      '{'0,   '0,   1,    1,    1'b1, 2},
      '{'0,   '0,   2,    2,    1'b1, 4},
      '{'0,   '0,   1,    '0,   1'b1, 3},
      '{5,    -3,   4,    -3,   1'b1, 3},
      '{CNEG1,'0,   '0,   '0,   1'b1, 3},
      '{CMIN, CMIN, CMAX, CMAX, 1'b0, 0},
      '{CMIN, '0,   CMAX, '0,   1'b0, 0},
      '{'0,   CMIN, '0,   CMAX, 1'b0, 0},
      '{CMAX, CMIN, CMIN, CMAX, 1'b0, 0},
      '{'0,   '0,   9,    9,    1'b0, 0},
      '{'0,   '0,   10,   '0,   1'b0, 0},
      '{'0,   '0,   '0,   10,   1'b0, 0},
      '{'0,   '0,   10,   10,   1'b0, 0},
      '{'0,   '0,   9,    8,    1'b0, 0},
      '{'0,   '0,   100,  3,    1'b0, 0},
      '{'0,   '0,   3,    1000, 1'b0, 0},
      '{CMIN, CMAX, CMAX, CMIN, 1'b0, 0},
      '{CMAX, '0,   CMIN, '0,   1'b0, 0},
      '{-7,   -7,   7,    7,    1'b0, 0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 0}
    };
    coord_t fx;
    coord_t fy;
    coord_t tx;
    coord_t ty;
    int     sent;
    int     burst;
    bit     held;
    bit     drained;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_pair(rows[i].fx, rows[i].fy, rows[i].tx, rows[i].ty, rows[i].fixed, rows[i].moves);
      idle_for($urandom_range(0, 2));
    end

    sent    = 0;
    held    = 1'b0;
    drained = 1'b0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 30);
      if (!held && sent >= 400) begin
        long_hold_req = 1'b1;
        held          = 1'b1;
        burst         = 200;
      end
      for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
        next_pair(fx, fy, tx, ty);
        send_pair(fx, fy, tx, ty, 1'b0, '0);
        sent++;
      end
      if (!drained && sent >= 800) begin
        wait_drained();
        drained = 1'b1;
      end else begin
        idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
    end

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_moves.size() != 0)
      report($sformatf("%0d predicted results never arrived", pending_moves.size()));
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
